// ----- src/amsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package amsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RAW_W    = 23;
    localparam int unsigned POS_W    = 25;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned SCALE_W  = 8;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned DIGIT_W  = 9;
    // wide enough for offset minus an exact 9x23 signed product
    localparam int unsigned WIDE_W   = 33;

    localparam logic [BYTE_W-1:0] MARK_FORCE    = 8'h41;
    localparam logic [BYTE_W-1:0] MARK_POSITION = 8'h42;
    localparam logic [BYTE_W-1:0] MINUS_CHAR    = 8'h2D;

    localparam logic signed [DIGIT_W-1:0] DIGIT_BASE = 9'sd48;
    localparam logic signed [RAW_W-1:0]   DIGIT_RADIX = 23'sd10;
    localparam logic [COUNT_W-1:0]        LAST_DIGIT = 3'd4;

    localparam logic signed [WIDE_W-1:0] POS_MAX = 33'sd16777215;
    localparam logic signed [WIDE_W-1:0] POS_MIN = -33'sd16777216;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd65000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd6;

    // configuration register indexes
    localparam logic [0:0] CFG_POSITION_OFFSET = 1'b0;
    localparam logic [0:0] CFG_POSITION_SCALE  = 1'b1;

    localparam logic CH_FORCE    = 1'b0;
    localparam logic CH_POSITION = 1'b1;

    typedef enum logic [0:0] {
        PH_HUNT   = 1'b0,
        PH_DIGITS = 1'b1
    } t_phase;

    typedef struct packed {
        logic                    channel;
        logic signed [RAW_W-1:0] raw_value;
        logic [INDEX_W-1:0]      sample_index;
    } t_frame;

endpackage

`default_nettype wire

// ----- src/amsd_rx_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface amsd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [amsd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/amsd_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface amsd_result_if;
    logic                                valid;
    logic                                ready;
    logic                                channel;
    logic signed [amsd_pkg::RAW_W-1:0]   raw_value;
    logic signed [amsd_pkg::POS_W-1:0]   position_milli;
    logic [amsd_pkg::INDEX_W-1:0]        sample_index;

    modport source (output valid, output channel, output raw_value,
                    output position_milli, output sample_index, input ready);
    modport sink   (input valid, input channel, input raw_value,
                    input position_milli, input sample_index, output ready);
endinterface

`default_nettype wire

// ----- src/amsd_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsd_frame_decoder (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    amsd_rx_if.sink               i_rx,
    output amsd_pkg::t_frame      o_frame,
    output logic                  o_frame_valid,
    input  wire logic             i_frame_ready
);

    amsd_pkg::t_phase                      r_phase, n_phase;
    logic                                  r_channel, n_channel;
    logic [amsd_pkg::COUNT_W-1:0]          r_count, n_count;
    logic signed [amsd_pkg::RAW_W-1:0]     r_acc, n_acc;
    logic                                  r_neg, n_neg;
    logic [amsd_pkg::INDEX_W-1:0]          r_force, n_force;
    logic                                  r_frame_valid, n_frame_valid;
    amsd_pkg::t_frame                      r_frame, n_frame;

    logic                                  w_accept;
    logic                                  w_is_marker;
    logic [amsd_pkg::BYTE_W-1:0]           w_own_mark;
    logic                                  w_restart;
    logic                                  w_minus;
    logic                                  w_last;
    logic signed [amsd_pkg::DIGIT_W-1:0]   w_digit;
    logic signed [amsd_pkg::RAW_W-1:0]     w_sum;
    logic signed [amsd_pkg::RAW_W-1:0]     w_value;

    assign i_rx.ready = !r_frame_valid || i_frame_ready;
    assign w_accept   = i_rx.valid && i_rx.ready;

    assign w_is_marker = (i_rx.rx_byte == amsd_pkg::MARK_FORCE)
                      || (i_rx.rx_byte == amsd_pkg::MARK_POSITION);
    assign w_own_mark  = r_channel ? amsd_pkg::MARK_POSITION : amsd_pkg::MARK_FORCE;
    assign w_restart   = (r_count == '0) && (i_rx.rx_byte == w_own_mark);
    assign w_minus     = (r_count == '0) && (i_rx.rx_byte == amsd_pkg::MINUS_CHAR);
    assign w_last      = (r_count == amsd_pkg::LAST_DIGIT);

    // horner step, partial sums always stay inside the raw range
    assign w_digit = $signed({1'b0, i_rx.rx_byte}) - amsd_pkg::DIGIT_BASE;
    assign w_sum   = r_acc * amsd_pkg::DIGIT_RADIX
                   + {{(amsd_pkg::RAW_W-amsd_pkg::DIGIT_W){w_digit[amsd_pkg::DIGIT_W-1]}},
                      w_digit};
    assign w_value = r_neg ? -w_sum : w_sum;

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                amsd_pkg::PH_HUNT: begin
                    if (w_is_marker) n_phase = amsd_pkg::PH_DIGITS;
                end
                amsd_pkg::PH_DIGITS: begin
                    if (!w_restart && w_last) n_phase = amsd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_channel     = r_channel;
        n_count       = r_count;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_force       = r_force;
        n_frame_valid = r_frame_valid && !i_frame_ready;
        n_frame       = r_frame;
        if (w_accept) begin
            unique case (r_phase)
                amsd_pkg::PH_HUNT: begin
                    if (w_is_marker) begin
                        n_channel = (i_rx.rx_byte == amsd_pkg::MARK_POSITION);
                        n_count   = '0;
                        n_acc     = '0;
                        n_neg     = 1'b0;
                    end
                end
                amsd_pkg::PH_DIGITS: begin
                    if (w_restart) begin
                        n_count = '0;
                        n_acc   = '0;
                        n_neg   = 1'b0;
                    end else if (w_last) begin
                        n_count               = '0;
                        n_acc                 = '0;
                        n_neg                 = 1'b0;
                        n_frame_valid         = 1'b1;
                        n_frame.channel       = r_channel;
                        n_frame.raw_value     = w_value;
                        n_frame.sample_index  = r_channel ? '0 : r_force;
                        if (r_channel == amsd_pkg::CH_FORCE) n_force = r_force + 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        if (w_minus) n_neg = 1'b1;
                        else         n_acc = w_sum;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= amsd_pkg::PH_HUNT;
            r_channel     <= 1'b0;
            r_count       <= '0;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_force       <= '0;
            r_frame_valid <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_channel     <= n_channel;
            r_count       <= n_count;
            r_acc         <= n_acc;
            r_neg         <= n_neg;
            r_force       <= n_force;
            r_frame_valid <= n_frame_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_frame       = r_frame;
    assign o_frame_valid = r_frame_valid;

endmodule

`default_nettype wire

// ----- src/amsd_position_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsd_position_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [amsd_pkg::OFFSET_W-1:0] i_cfg_wdata,
    input  wire amsd_pkg::t_frame              i_frame,
    input  wire logic                          i_frame_valid,
    output logic                               o_frame_ready,
    amsd_result_if.source                      o_res
);

    logic [amsd_pkg::OFFSET_W-1:0]      r_offset;
    logic [amsd_pkg::SCALE_W-1:0]       r_scale;
    logic                               r_out_valid;
    logic                               r_channel;
    logic signed [amsd_pkg::RAW_W-1:0]  r_raw;
    logic signed [amsd_pkg::POS_W-1:0]  r_pos;
    logic [amsd_pkg::INDEX_W-1:0]       r_index;

    logic                                             w_take;
    logic signed [amsd_pkg::SCALE_W+amsd_pkg::RAW_W:0] w_product;
    logic signed [amsd_pkg::WIDE_W-1:0]               w_diff;
    logic signed [amsd_pkg::POS_W-1:0]                w_sat;

    assign o_frame_ready = !r_out_valid || o_res.ready;
    assign w_take        = i_frame_valid && o_frame_ready;

    assign w_product = $signed({1'b0, r_scale}) * i_frame.raw_value;
    assign w_diff    = $signed({{(amsd_pkg::WIDE_W-amsd_pkg::OFFSET_W){1'b0}}, r_offset})
                     - {{(amsd_pkg::WIDE_W-amsd_pkg::SCALE_W-amsd_pkg::RAW_W-1)
                         {w_product[amsd_pkg::SCALE_W+amsd_pkg::RAW_W]}}, w_product};

    always_comb begin
        if (w_diff > amsd_pkg::POS_MAX)      w_sat = amsd_pkg::POS_MAX[amsd_pkg::POS_W-1:0];
        else if (w_diff < amsd_pkg::POS_MIN) w_sat = amsd_pkg::POS_MIN[amsd_pkg::POS_W-1:0];
        else                                 w_sat = w_diff[amsd_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= amsd_pkg::OFFSET_RESET;
            r_scale     <= amsd_pkg::SCALE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    amsd_pkg::CFG_POSITION_OFFSET: r_offset <= i_cfg_wdata;
                    amsd_pkg::CFG_POSITION_SCALE:
                        r_scale <= i_cfg_wdata[amsd_pkg::SCALE_W-1:0];
                endcase
            end
            if (w_take)           r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_channel <= i_frame.channel;
            r_raw     <= i_frame.raw_value;
            r_pos     <= (i_frame.channel == amsd_pkg::CH_POSITION) ? w_sat : '0;
            r_index   <= i_frame.sample_index;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.channel        = r_channel;
    assign o_res.raw_value      = r_raw;
    assign o_res.position_milli = r_pos;
    assign o_res.sample_index   = r_index;

endmodule

`default_nettype wire

// ----- src/ascii_marker_sample_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                            handshake
// i_rx      in   rx_byte[7:0]                                       valid/ready
// o_res     out  channel, raw_value[22:0], position_milli[24:0],    valid/ready
//                sample_index[15:0]
// i_cfg_*   in   idx 0 position_offset[19:0], idx 1 position_scale  write enable
//
// one byte accepted per cycle while i_rx is ready; after a frame's last byte its
// result goes to the frame register, then through the position multiply into o_res
// synchronous active-low reset clears frame state, force count, both valid
// flags and loads offset 65000 and scale 6
// a stalled o_res holds its result; i_rx stays ready while the frame register
// is free or can move on, so two results can be in flight

module ascii_marker_sample_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [amsd_pkg::OFFSET_W-1:0] i_cfg_wdata,
    amsd_rx_if.sink                            i_rx,
    amsd_result_if.source                      o_res
);

    // completed frame between marker/digit tracking and the position stage
    amsd_pkg::t_frame w_frame;
    logic             w_frame_valid;
    logic             w_frame_ready;

    // marker hunt, repeated-marker restart, minus sign and horner accumulation,
    // plus the running force-frame index
    amsd_frame_decoder u_frame_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (i_rx),
        .o_frame       (w_frame),
        .o_frame_valid (w_frame_valid),
        .i_frame_ready (w_frame_ready)
    );

    // offset minus scale times value, saturated, for position frames (zero for force
    // frames), and the output register; also holds the two configuration registers
    amsd_position_stage u_position_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_frame       (w_frame),
        .i_frame_valid (w_frame_valid),
        .o_frame_ready (w_frame_ready),
        .o_res         (o_res)
    );

endmodule

`default_nettype wire

// ----- src/amsd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsd_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    amsd_rx_if.sink       i_rx,
    amsd_result_if.source o_res
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.channel)
            && $stable(o_res.raw_value) && $stable(o_res.position_milli)
            && $stable(o_res.sample_index))
        else $error("stalled result changed");

    // each channel carries only its own derived field
    a_channel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.channel ? (o_res.sample_index == '0)
                                       : (o_res.position_milli == '0)))
        else $error("derived field of other channel not zero");

    // with the output register empty the input side never stalls
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_rx.ready)
        else $error("input stalled while output empty");

endmodule

bind ascii_marker_sample_decoder amsd_checker u_amsd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_rx    (i_rx),
    .o_res   (o_res)
);

`default_nettype wire
